### sv/fcv_pkg.sv
// Package for the frame check verifier: check constants, the result record,
// the starting check per mode and the single-byte CRC-16/MODBUS update.
// No dependencies.
`default_nettype none

package fcv_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHECK_W = 16;

    // Check modes
    typedef enum logic {
        MODE_CRC = 1'b0,
        MODE_SUM = 1'b1
    } check_mode_t;

    // Check constants
    localparam logic [CHECK_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CHECK_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CHECK_W-1:0] SUM_INIT = 16'h0000;

    // Stream widths: tdata holds check_ok, computed_check, received_check
    localparam int unsigned M_DATA_BITS = 1 + 2 * CHECK_W;
    localparam int unsigned M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // One result
    typedef struct packed {
        logic               check_ok;
        logic [CHECK_W-1:0] computed_check;
        logic [CHECK_W-1:0] received_check;
        logic               frame_too_short;
    } result_t;

    // Starting value of the running check for a mode
    function automatic logic [CHECK_W-1:0] initial_check(input check_mode_t mode);
        initial_check = (mode == MODE_SUM) ? SUM_INIT : CRC_INIT;
    endfunction

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [CHECK_W-1:0] crc16_byte(
        input logic [CHECK_W-1:0] acc,
        input logic [BYTE_W-1:0]  data
    );
        logic [CHECK_W-1:0] crc;
        crc = acc ^ {{(CHECK_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        crc16_byte = crc;
    endfunction

endpackage

`default_nettype wire

### sv/frame_check_verifier.sv
// Frame check verifier top level: byte stream in, one result per frame out.
// Depends on fcv_pkg and fcv_absorb.
`default_nettype none

// Takes a frame one byte per transfer on the s_ side, s_tlast on the final
// byte; the last two bytes are the check value, low byte first. cfg_data
// selects CRC-16/MODBUS (0) or a 16-bit wrapping byte sum (1); a write
// restarts any frame in progress and should be made while the block is idle.
// One byte is taken every clock cycle while s_tready is high: the CRC update
// over a byte is a single unrolled step between the held-byte registers and
// the running check. A result is registered into the output register, or
// into the skid entry while an older one waits; this two-entry buffer lets
// input continue, and s_tready drops only when two results are pending.
module frame_check_verifier (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration: bit 0 = check_mode
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,
    // input stream: tdata[7:0] = data_byte, tlast = last_byte
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [fcv_pkg::BYTE_W-1:0]        s_tdata,
    input  wire logic                              s_tlast,
    // result stream: tdata[0] = check_ok, [16:1] = computed_check,
    // [32:17] = received_check, upper bits zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [fcv_pkg::M_TDATA_W-1:0]          m_tdata,
    // tuser[0] = frame_too_short
    output logic                                   m_tuser
);
    import fcv_pkg::*;

    // Frame state
    check_mode_t        mode_reg;
    logic [CHECK_W-1:0] running_check_reg, running_check_next;
    logic [BYTE_W-1:0]  held0_reg, held0_next;
    logic [BYTE_W-1:0]  held1_reg, held1_next;
    logic [1:0]         held_count_reg, held_count_next;

    // Output buffer
    result_t main_reg, skid_reg, result_next;
    logic    main_valid_reg, skid_valid_reg;

    logic               in_xfer, out_xfer, cfg_xfer, push;
    logic [CHECK_W-1:0] absorbed;
    logic [CHECK_W-1:0] check_after;
    logic [CHECK_W-1:0] rx_check;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_tready  = !skid_valid_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = main_valid_reg && m_tready;
    assign push      = in_xfer && s_tlast;

    // Oldest held byte enters the running check
    fcv_absorb u_absorb (
        .mode    (mode_reg),
        .acc     (running_check_reg),
        .data    (held0_reg),
        .acc_out (absorbed)
    );

    // Delay line shift and result build
    always_comb begin
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        check_after     = running_check_reg;
        priority if (held_count_reg == 2'd2) begin
            check_after = absorbed;
            held0_next  = held1_reg;
            held1_next  = s_tdata;
        end else if (held_count_reg == 2'd1) begin
            held1_next      = s_tdata;
            held_count_next = 2'd2;
        end else begin
            held0_next      = s_tdata;
            held_count_next = 2'd1;
        end
        rx_check = {held1_next, held0_next};

        if (held_count_reg == 2'd0) begin
            result_next.check_ok        = 1'b0;
            result_next.computed_check  = check_after;
            result_next.received_check  = '0;
            result_next.frame_too_short = 1'b1;
        end else begin
            result_next.check_ok        = (check_after == rx_check);
            result_next.computed_check  = check_after;
            result_next.received_check  = rx_check;
            result_next.frame_too_short = 1'b0;
        end

        running_check_next = check_after;
        if (s_tlast) begin
            running_check_next = initial_check(mode_reg);
            held_count_next    = 2'd0;
        end
    end

    // Frame state registers; a mode write wins over a byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_CRC;
            running_check_reg <= CRC_INIT;
            held_count_reg    <= 2'd0;
        end else if (cfg_xfer) begin
            mode_reg          <= check_mode_t'(cfg_data);
            running_check_reg <= initial_check(check_mode_t'(cfg_data));
            held_count_reg    <= 2'd0;
        end else if (in_xfer) begin
            running_check_reg <= running_check_next;
            held_count_reg    <= held_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // Output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_xfer) begin
                    main_reg       <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (main_valid_reg && !out_xfer) begin
                if (push) begin
                    skid_reg       <= result_next;
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                main_valid_reg <= push;
                if (push) begin
                    main_reg <= result_next;
                end
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_DATA_BITS){1'b0}},
                       main_reg.received_check,
                       main_reg.computed_check,
                       main_reg.check_ok};
    assign m_tuser  = main_reg.frame_too_short;

`ifndef SYNTHESIS
    // Delay line never claims more than two bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3)
        else $error("held byte count out of range");

    // Skid entry only fills behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without main entry");

    // Frame state restarts after a last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tlast) |=> (held_count_reg == 2'd0))
        else $error("frame state not cleared after last byte");

    // A mode write loads the starting check of the new mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_xfer |=> (running_check_reg == initial_check(mode_reg)
                      && held_count_reg == 2'd0))
        else $error("running check not restarted on mode write");

    // A short frame never reports a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(main_reg.check_ok && main_reg.frame_too_short))
        else $error("short frame flagged as matching");
`endif

endmodule

`default_nettype wire

### sv/fcv_absorb.sv
// Running check update: folds one payload byte into the CRC or the sum.
// Depends on fcv_pkg.
`default_nettype none

module fcv_absorb (
    input  wire fcv_pkg::check_mode_t                mode,
    input  wire logic [fcv_pkg::CHECK_W-1:0]         acc,
    input  wire logic [fcv_pkg::BYTE_W-1:0]          data,
    output logic [fcv_pkg::CHECK_W-1:0]              acc_out
);
    import fcv_pkg::*;

    logic [CHECK_W-1:0] crc_value;
    logic [CHECK_W-1:0] sum_value;

    // Both updates in parallel, mode picks one
    assign crc_value = crc16_byte(acc, data);
    assign sum_value = acc + {{(CHECK_W-BYTE_W){1'b0}}, data};

    always_comb begin
        unique case (mode)
            MODE_SUM: acc_out = sum_value;
            default:  acc_out = crc_value;
        endcase
    end

endmodule

`default_nettype wire
